@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DIF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/dif_pkg.sv @@
`default_nettype none

package dif_pkg;

  localparam int BOOT_BYTES = 512;
  localparam int COUNT_BITS = 27;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  localparam logic [3:0][31:0] MIX_INIT = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] SECTOR_LO_POS = 32'd11;
  localparam logic [31:0] SECTOR_HI_POS = 32'd12;
  localparam logic [31:0] MEDIA_POS     = 32'd21;
  localparam logic [15:0] DOS_SECTOR_SIZE = 16'd512;

  localparam logic [7:0] MEDIA_F0 = 8'hF0;
  localparam logic [7:0] MEDIA_F9 = 8'hF9;
  localparam logic [7:0] MEDIA_FD = 8'hFD;
  localparam logic [7:0] MEDIA_FF = 8'hFF;

  typedef struct packed {
    logic        fire;
    logic        last;
    logic        boot_hit;
    logic [31:0] pos;
    logic [7:0]  data;
  } step_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    c = crc ^ {24'b0, d};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/dif_if.sv @@
`default_nettype none

interface dif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dif_out_if #(
  parameter int COUNT_BITS = dif_pkg::COUNT_BITS
);
  logic                  valid;
  logic                  ready;
  logic [31:0]           image_crc;
  logic [31:0]           sector_crc;
  logic [31:0]           hash_word_zero;
  logic [31:0]           hash_word_one;
  logic [31:0]           hash_word_two;
  logic [31:0]           hash_word_three;
  logic [COUNT_BITS-1:0] image_length;
  logic                  length_overflow;
  logic                  msdos_boot;

  modport source (
    output valid, output image_crc, output sector_crc,
    output hash_word_zero, output hash_word_one, output hash_word_two,
    output hash_word_three, output image_length, output length_overflow,
    output msdos_boot, input ready
  );
  modport sink (
    input valid, input image_crc, input sector_crc,
    input hash_word_zero, input hash_word_one, input hash_word_two,
    input hash_word_three, input image_length, input length_overflow,
    input msdos_boot, output ready
  );
endinterface

`default_nettype wire

@@ src/dif_crc_unit.sv @@
`default_nettype none

module dif_crc_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dif_pkg::step_t step,
  output logic [31:0]         image_crc,
  output logic [31:0]         sector_crc
);

  logic [31:0] running_crc;
  logic [31:0] sector_crc_hold;
  logic [31:0] crc_upd;

  always_comb begin
    crc_upd    = dif_pkg::crc_byte(running_crc, step.data);
    image_crc  = crc_upd ^ dif_pkg::CRC_ALL_ONES;
    sector_crc = step.boot_hit ? image_crc : sector_crc_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= dif_pkg::CRC_ALL_ONES;
      sector_crc_hold <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        running_crc     <= dif_pkg::CRC_ALL_ONES;
        sector_crc_hold <= '0;
      end else begin
        running_crc     <= crc_upd;
        sector_crc_hold <= sector_crc;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dif_mix_unit.sv @@
`default_nettype none

module dif_mix_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dif_pkg::step_t step,
  output logic [3:0][31:0]    words
);

  logic [3:0][31:0] mix_words;
  logic [1:0]       lane;
  logic [1:0]       lane_up;
  logic [31:0]      mult;
  logic [31:0]      prod;

  always_comb begin
    words   = mix_words;
    lane    = step.pos[1:0];
    lane_up = lane + 2'd1;
    mult    = step.pos + 32'd1;
    prod    = mult * {24'b0, step.data};
    words[lane]    = mix_words[lane] ^ ({24'b0, step.data} << {lane, 3'b000});
    words[lane_up] = mix_words[lane_up] + prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_words <= dif_pkg::MIX_INIT;
    end else if (step.fire) begin
      mix_words <= step.last ? dif_pkg::MIX_INIT : words;
    end
  end

endmodule

`default_nettype wire

@@ src/disk_image_fingerprint_top.sv @@
// Streams a disk image one byte per item and returns one result item per image, taken
// from the byte marked last: whole-image CRC-32, CRC-32 of the first BOOT_BYTES bytes
// (zero if shorter), four position-mixed hash words, the saturating byte count with an
// overflow flag, and a DOS boot sector flag. Throughput is one byte per clock: each
// byte is registered on accept and folded into the running CRC and hash state as it
// leaves that register, by one byte-wide CRC step and one 8x32 multiply-add. A result
// item is loaded into an output register as its last byte leaves the input register;
// only a last byte waiting there while an earlier result is untaken holds the input side.
`default_nettype none
`include "assert_macros.svh"

module disk_image_fingerprint_top #(
  parameter int BOOT_BYTES = dif_pkg::BOOT_BYTES,
  parameter int COUNT_BITS = dif_pkg::COUNT_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  dif_in_if.sink    bytes,
  dif_out_if.source result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [32:0] BOOT_MARK = 33'(BOOT_BYTES);

  // input register
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       s1_adv;

  // per-image state
  logic [COUNT_BITS-1:0] byte_count;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic                  count_overflowed;
  logic                  count_overflowed_next;
  logic [15:0]           sector_size_bytes;
  logic [15:0]           sector_size_bytes_next;
  logic [7:0]            media_code;
  logic [7:0]            media_code_next;

  logic [31:0]      pos;
  logic [32:0]      pos_plus;
  logic             count_sat;
  logic             long_enough;
  logic             dos_media;
  logic             load;
  dif_pkg::step_t   step;
  logic [31:0]      crc_full;
  logic [31:0]      crc_boot;
  logic [3:0][31:0] mix;

  // result register
  logic                  out_valid;
  logic [31:0]           image_crc;
  logic [31:0]           sector_crc;
  logic [3:0][31:0]      hash_words;
  logic [COUNT_BITS-1:0] image_length;
  logic                  length_overflow;
  logic                  msdos_boot;

  assign s1_adv      = s1_valid && (!s1_last || !out_valid || result.ready);
  assign bytes.ready = !s1_valid || s1_adv;
  assign load        = s1_adv && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_data <= bytes.data_byte;
      s1_last <= bytes.last_byte;
    end
  end

  always_comb begin
    pos       = 32'(byte_count);
    pos_plus  = 33'(byte_count) + 33'd1;
    count_sat = byte_count == COUNT_MAX;
    byte_count_next       = count_sat ? byte_count : byte_count + COUNT_BITS'(1);
    count_overflowed_next = count_overflowed | count_sat;

    sector_size_bytes_next = sector_size_bytes;
    media_code_next        = media_code;
    if (pos == dif_pkg::SECTOR_LO_POS) begin
      sector_size_bytes_next = {sector_size_bytes[15:8], s1_data};
    end else if (pos == dif_pkg::SECTOR_HI_POS) begin
      sector_size_bytes_next = {s1_data, sector_size_bytes[7:0]};
    end else if (pos == dif_pkg::MEDIA_POS) begin
      media_code_next = s1_data;
    end

    long_enough = 33'(byte_count_next) >= BOOT_MARK;
    dos_media   = media_code_next == dif_pkg::MEDIA_F0 ||
                  media_code_next == dif_pkg::MEDIA_F9 ||
                  media_code_next == dif_pkg::MEDIA_FD ||
                  media_code_next == dif_pkg::MEDIA_FF;

    step.fire     = s1_adv;
    step.last     = s1_last;
    step.boot_hit = pos_plus == BOOT_MARK;
    step.pos      = pos;
    step.data     = s1_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      count_overflowed  <= 1'b0;
      sector_size_bytes <= '0;
      media_code        <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        byte_count        <= '0;
        count_overflowed  <= 1'b0;
        sector_size_bytes <= '0;
        media_code        <= '0;
      end else begin
        byte_count        <= byte_count_next;
        count_overflowed  <= count_overflowed_next;
        sector_size_bytes <= sector_size_bytes_next;
        media_code        <= media_code_next;
      end
    end
  end

  dif_crc_unit u_crc (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .image_crc  (crc_full),
    .sector_crc (crc_boot)
  );

  dif_mix_unit u_mix (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .words (mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      image_crc       <= crc_full;
      sector_crc      <= long_enough ? crc_boot : 32'd0;
      hash_words      <= mix;
      image_length    <= byte_count_next;
      length_overflow <= count_overflowed_next;
      msdos_boot      <= long_enough && dos_media &&
                         sector_size_bytes_next == dif_pkg::DOS_SECTOR_SIZE;
    end
  end

  assign result.valid           = out_valid;
  assign result.image_crc       = image_crc;
  assign result.sector_crc      = sector_crc;
  assign result.hash_word_zero  = hash_words[0];
  assign result.hash_word_one   = hash_words[1];
  assign result.hash_word_two   = hash_words[2];
  assign result.hash_word_three = hash_words[3];
  assign result.image_length    = image_length;
  assign result.length_overflow = length_overflow;
  assign result.msdos_boot      = msdos_boot;

  `DIF_ASSERT_NEXT(a_last_gives_result, clk, rst, load, out_valid)
  `DIF_ASSERT_NEXT(a_state_clears, clk, rst, load, byte_count == '0 && !count_overflowed)
  `DIF_ASSERT_SAME(a_overflow_saturated, clk, rst, count_overflowed, byte_count == COUNT_MAX)
  `DIF_ASSERT_SAME(a_no_lost_result, clk, rst, out_valid && !result.ready, !load)

endmodule

`default_nettype wire
